FILE: sv/lrt_pkg.sv
// Shared types, constants, sigmoid table and saturation helpers for the trainer.
package lrt_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int FEAT_W      = 16;
    localparam int SIG_DEPTH   = 256;
    localparam int SIG_IDX_W   = $clog2(SIG_DEPTH);
    localparam int SIG_SHIFT   = 20 - SIG_IDX_W;

    localparam logic [31:0] ONE_Q16      = 32'h0001_0000;
    localparam longint      HALF_RANGE   = 524288;
    localparam logic [63:0] E_Q32        = 64'd11674931555;

    localparam logic [15:0] LEARN_RATE_RST  = 16'd66;
    localparam logic [15:0] EPOCH_COUNT_RST = 16'd999;

    // Configuration register indexes
    typedef enum logic {
        REG_LEARN_RATE  = 1'b0,
        REG_EPOCH_COUNT = 1'b1
    } t_reg_idx;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_Z,
        ST_P,
        ST_EX,
        ST_ACC,
        ST_U0,
        ST_U1,
        ST_U2
    } t_state;

    typedef logic [16:0] t_sig_tab [SIG_DEPTH];

    // e^t in Q16.16 for 0 <= t < 8.0
    function automatic logic [63:0] f_exp_q16(input logic [63:0] t);
        logic [63:0] n;
        logic [63:0] f;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] val;
        n    = t >> 16;
        f    = t & 64'hFFFF;
        sum  = 64'd1 << 32;
        term = 64'd1 << 32;
        term = ((term * f) >> 16) / 1;  sum = sum + term;
        term = ((term * f) >> 16) / 2;  sum = sum + term;
        term = ((term * f) >> 16) / 3;  sum = sum + term;
        term = ((term * f) >> 16) / 4;  sum = sum + term;
        term = ((term * f) >> 16) / 5;  sum = sum + term;
        term = ((term * f) >> 16) / 6;  sum = sum + term;
        term = ((term * f) >> 16) / 7;  sum = sum + term;
        term = ((term * f) >> 16) / 8;  sum = sum + term;
        term = ((term * f) >> 16) / 9;  sum = sum + term;
        term = ((term * f) >> 16) / 10; sum = sum + term;
        term = ((term * f) >> 16) / 11; sum = sum + term;
        term = ((term * f) >> 16) / 12; sum = sum + term;
        val = sum >> 16;
        for (int k = 0; k < 8; k++) begin
            if (64'(k) < n) begin
                val = (val * E_Q32) >> 32;
            end
        end
        return val;
    endfunction

    // Restoring long division for table build
    function automatic logic [63:0] f_udiv(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Sigmoid of each bin center over [-8, 8), Q0.16
    function automatic t_sig_tab f_build_sig();
        t_sig_tab    tab;
        longint      zc;
        logic [63:0] t;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] p;
        for (int i = 0; i < SIG_DEPTH; i++) begin
            zc  = ((2 * longint'(i) + 1) * HALF_RANGE) / SIG_DEPTH - HALF_RANGE;
            t   = (zc < 0) ? 64'(-zc) : 64'(zc);
            e   = f_exp_q16(t);
            den = e + 64'd65536;
            p   = f_udiv((e << 16) + (den >> 1), den);
            tab[i] = (zc < 0) ? 17'(64'd65536 - p) : 17'(p);
        end
        return tab;
    endfunction

    localparam t_sig_tab SIG_TABLE = f_build_sig();

    // Clamp a 49-bit sum to 48-bit signed
    function automatic logic signed [47:0] f_sat48(input logic signed [48:0] v);
        if (v[48] != v[47]) begin
            return v[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end
        return v[47:0];
    endfunction

    // Clamp a 51-bit value to 32-bit signed
    function automatic logic signed [31:0] f_sat32(input logic signed [50:0] v);
        if (v > 51'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -51'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

FILE: sv/logistic_regression_trainer_unit.sv
// Top level: sample loading, training sequencer and shared multiplier datapath.
// Loading: one sample beat per cycle while o_busy is low.
// Training: each stored sample runs the read, z, sigmoid, error and accumulate steps,
// and each pass ends with a bias then slope weight update; the single shared
// multiplier and the single read port of the sample store set this order.
// The result shows for one cycle on o_valid; the receiver cannot stall.
// Synchronous active-low reset clears control state, weights to 1.0, rate 66, epochs 999.
module logistic_regression_trainer_unit
    import lrt_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic                     i_label,
    input  logic signed [FEAT_W-1:0] i_feature,
    input  logic                     i_last_sample,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_idx,
    input  logic [15:0]              i_cfg_data,
    output logic                     o_valid,
    output logic signed [31:0]       o_bias_weight,
    output logic signed [31:0]       o_slope_weight
);

    t_state                r_state, n_state;
    logic [15:0]           r_lr;
    logic [15:0]           r_epochs;
    logic [CNT_W-1:0]      r_count;
    logic [ADDR_W-1:0]     r_idx;
    logic [15:0]           r_pass;
    logic                  r_phase;
    logic                  r_valid;
    logic signed [31:0]    r_bias;
    logic signed [31:0]    r_slope;
    logic signed [47:0]    r_bsum;
    logic signed [47:0]    r_ssum;
    logic signed [17:0]    r_e;
    logic signed [57:0]    r_prod;
    logic signed [57:0]    r_lo;

    logic                  wr_en;
    logic [FEAT_W:0]       rdata;
    logic signed [FEAT_W-1:0] rd_x;
    logic                  rd_lab;
    logic signed [32:0]    m_a;
    logic signed [24:0]    m_b;
    logic signed [57:0]    m_prod;
    logic signed [47:0]    upd_sum;
    logic signed [41:0]    z;
    logic signed [41:0]    zs;
    logic [41:0]           zsh;
    logic [SIG_IDX_W-1:0]  sig_idx;
    logic [16:0]           p_val;
    logic signed [65:0]    upd_full;
    logic signed [50:0]    upd_w;
    logic signed [31:0]    upd_old;
    logic                  last_sample_done;
    logic                  pass_done;

    assign wr_en = (r_state == ST_IDLE) && i_start && (r_count < CNT_W'(MAX_SAMPLES));

    lrt_store u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata ({i_label, i_feature}),
        .i_raddr (r_idx),
        .o_rdata (rdata)
    );

    assign rd_x   = rdata[FEAT_W-1:0];
    assign rd_lab = rdata[FEAT_W];

    // Select multiplier operands for the current step
    assign upd_sum = r_phase ? r_ssum : r_bsum;
    always_comb begin
        m_a = '0;
        m_b = '0;
        case (r_state)
            ST_Z: begin
                m_a = 33'(r_slope);
                m_b = 25'(rd_x);
            end
            ST_EX: begin
                m_a = 33'(r_e);
                m_b = 25'(rd_x);
            end
            ST_U0: begin
                m_a = {17'd0, r_lr};
                m_b = {1'b0, upd_sum[23:0]};
            end
            ST_U1: begin
                m_a = {17'd0, r_lr};
                m_b = {upd_sum[47], upd_sum[47:24]};
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    // Shared signed multiplier
    assign m_prod = m_a * m_b;

    // Sigmoid bin lookup from z
    assign z   = 42'(r_bias) + 42'(r_prod >>> 8);
    assign zs  = z + 42'(HALF_RANGE);
    assign zsh = 42'(zs) >> SIG_SHIFT;
    always_comb begin
        if (zs < 0) begin
            sig_idx = '0;
        end else if (zsh >= 42'(SIG_DEPTH)) begin
            sig_idx = SIG_IDX_W'(SIG_DEPTH - 1);
        end else begin
            sig_idx = zsh[SIG_IDX_W-1:0];
        end
    end
    assign p_val = SIG_TABLE[sig_idx];

    // Weight step: round learn_rate * sum and saturate
    assign upd_old  = r_phase ? r_slope : r_bias;
    assign upd_full = (66'(r_prod) <<< 24) + 66'(r_lo) + 66'sd32768;
    assign upd_w    = 51'(upd_old) + 51'(upd_full >>> 16);

    assign last_sample_done = ({1'b0, r_idx} + 1'b1) >= r_count;
    assign pass_done        = (r_pass + 16'd1) == r_epochs;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start && i_last_sample) begin
                    n_state = (r_epochs == '0) ? ST_IDLE : ST_RD;
                end
            end
            ST_RD:  n_state = ST_Z;
            ST_Z:   n_state = ST_P;
            ST_P:   n_state = ST_EX;
            ST_EX:  n_state = ST_ACC;
            ST_ACC: n_state = last_sample_done ? ST_U0 : ST_RD;
            ST_U0:  n_state = ST_U1;
            ST_U1:  n_state = ST_U2;
            ST_U2: begin
                if (!r_phase) begin
                    n_state = ST_U0;
                end else if (pass_done) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_RD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_lr     <= LEARN_RATE_RST;
            r_epochs <= EPOCH_COUNT_RST;
            r_count  <= '0;
            r_idx    <= '0;
            r_pass   <= '0;
            r_phase  <= 1'b0;
            r_valid  <= 1'b0;
            r_bias   <= ONE_Q16;
            r_slope  <= ONE_Q16;
            r_bsum   <= '0;
            r_ssum   <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_idx))
                    REG_LEARN_RATE:  r_lr     <= i_cfg_data;
                    REG_EPOCH_COUNT: r_epochs <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                ST_IDLE: begin
                    if (wr_en) begin
                        r_count <= r_count + 1'b1;
                    end
                    if (i_start && i_last_sample) begin
                        r_bias  <= ONE_Q16;
                        r_slope <= ONE_Q16;
                        r_bsum  <= '0;
                        r_ssum  <= '0;
                        r_pass  <= '0;
                        r_idx   <= '0;
                        r_phase <= 1'b0;
                        if (r_epochs == '0) begin
                            r_valid <= 1'b1;
                            r_count <= '0;
                        end
                    end
                end
                ST_EX: begin
                    r_bsum <= f_sat48(49'(r_bsum) + 49'(r_e));
                end
                ST_ACC: begin
                    r_ssum <= f_sat48(49'(r_ssum) + 49'(r_prod >>> 8));
                    r_idx  <= r_idx + 1'b1;
                end
                ST_U2: begin
                    if (!r_phase) begin
                        r_bias  <= f_sat32(upd_w);
                        r_phase <= 1'b1;
                    end else begin
                        r_slope <= f_sat32(upd_w);
                        r_phase <= 1'b0;
                        r_pass  <= r_pass + 16'd1;
                        r_idx   <= '0;
                        r_bsum  <= '0;
                        r_ssum  <= '0;
                        if (pass_done) begin
                            r_valid <= 1'b1;
                            r_count <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers: shared product, error term, low partial product
    always_ff @(posedge i_clk) begin
        r_prod <= m_prod;
        if (r_state == ST_P) begin
            r_e <= (rd_lab ? 18'sd65536 : 18'sd0) - 18'(p_val);
        end
        if (r_state == ST_U1) begin
            r_lo <= r_prod;
        end
    end

    assign o_busy         = (r_state != ST_IDLE);
    assign o_valid        = r_valid;
    assign o_bias_weight  = r_bias;
    assign o_slope_weight = r_slope;

    // Result strobe: one cycle, idle only; sample count bounded and zero on the strobe
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy) else $error("result while busy");
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe held");
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SAMPLES)) else $error("sample count overflow");
    a_count_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_count == '0)) else $error("store not emptied");

endmodule

FILE: sv/lrt_store.sv
// Sample store: one label bit and one feature per entry, registered read.
module lrt_store
    import lrt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [FEAT_W:0]   i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [FEAT_W:0]   o_rdata
);

    logic [FEAT_W:0] r_mem [MAX_SAMPLES];
    logic [FEAT_W:0] r_rdata;

    // Write one entry, read one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the logistic regression trainer unit.
module tb_top
    import lrt_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        logic signed [31:0] bias;
        logic signed [31:0] slope;
    } t_weights;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic               o_busy;
    logic               i_label = 1'b0;
    logic signed [15:0] i_feature = '0;
    logic               i_last_sample = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_idx = REG_LEARN_RATE;
    logic [15:0]        i_cfg_data = '0;
    logic               o_valid;
    logic signed [31:0] o_bias_weight;
    logic signed [31:0] o_slope_weight;

    logistic_regression_trainer_unit dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state
    longint unsigned    sig_lut [SIG_DEPTH];
    logic signed [15:0] feat_mem [MAX_SAMPLES];
    bit                 label_mem [MAX_SAMPLES];
    int                 n_stored;
    logic [15:0]        rate_q;
    logic [15:0]        epochs_q;
    t_weights           weights_q [$];
    int                 n_errors;
    int                 n_cycles;
    bit                 idle_on;

    // e^t in Q16.16, 0 <= t < 8
    function automatic longint unsigned exp_fixed(longint unsigned t);
        longint unsigned frac, acc, term, val;
        frac = t & 64'hFFFF;
        acc  = 64'd1 << 32;
        term = 64'd1 << 32;
        for (int k = 1; k <= 12; k++) begin
            term = ((term * frac) >> 16) / k;
            acc  = acc + term;
        end
        val = acc >> 16;
        for (int k = 0; k < 8 && k < (t >> 16); k++) begin
            val = (val * 64'd11674931555) >> 32;
        end
        return val;
    endfunction

    function automatic void fill_sigmoid_lut();
        longint          zc;
        longint unsigned mag, ex, den, p;
        for (int i = 0; i < SIG_DEPTH; i++) begin
            zc  = ((2 * longint'(i) + 1) * 524288) / SIG_DEPTH - 524288;
            mag = (zc < 0) ? -zc : zc;
            ex  = exp_fixed(mag);
            den = ex + 65536;
            p   = ((ex << 16) + den / 2) / den;
            sig_lut[i] = (zc < 0) ? 65536 - p : p;
        end
    endfunction

    function automatic longint sigmoid_of(longint z);
        longint s, idx;
        s = z + 524288;
        if (s < 0) begin
            return sig_lut[0];
        end
        idx = (s * SIG_DEPTH) >>> 20;
        if (idx >= SIG_DEPTH) begin
            idx = SIG_DEPTH - 1;
        end
        return sig_lut[idx];
    endfunction

    function automatic longint clamp48(longint v);
        if (v > 64'sd140737488355327) return 64'sd140737488355327;
        if (v < -64'sd140737488355328) return -64'sd140737488355328;
        return v;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Run gradient descent over the stored set and queue the weights
    function automatic void train_weights();
        longint   b, s, gb, gs, x, e;
        t_weights w;
        b = 65536;
        s = 65536;
        for (int ep = 0; ep < epochs_q; ep++) begin
            gb = 0;
            gs = 0;
            for (int i = 0; i < n_stored; i++) begin
                x  = longint'(feat_mem[i]);
                e  = (label_mem[i] ? 65536 : 0) - sigmoid_of(b + ((s * x) >>> 8));
                gb = clamp48(gb + e);
                gs = clamp48(gs + ((e * x) >>> 8));
            end
            b = clamp32(b + ((longint'(rate_q) * gb + 32768) >>> 16));
            s = clamp32(s + ((longint'(rate_q) * gs + 32768) >>> 16));
        end
        w.bias  = b[31:0];
        w.slope = s[31:0];
        weights_q.push_back(w);
        n_stored = 0;
    endfunction

    // Store one accepted sample beat; drop it once the store is full; train on the last beat
    function automatic void absorb_sample(bit lab, logic signed [15:0] feat, bit last);
        if (n_stored < MAX_SAMPLES) begin
            feat_mem[n_stored]  = feat;
            label_mem[n_stored] = lab;
            n_stored++;
        end
        if (last) begin
            train_weights();
        end
    endfunction

    // Drive one sample beat and hold it until accepted
    task automatic send_sample(bit lab, logic signed [15:0] feat, bit last);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_start       <= 1'b1;
        i_label       <= lab;
        i_feature     <= feat;
        i_last_sample <= last;
        do @(posedge i_clk); while (o_busy);
        absorb_sample(lab, feat, last);
    endtask

    // Hold off until every expected result is back and the block is idle
    task automatic drain();
        i_start <= 1'b0;
        while (weights_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [15:0] data);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == REG_LEARN_RATE) rate_q = data;
        else epochs_q = data;
    endtask

    function automatic logic signed [15:0] pick_feature();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'(int'($urandom_range(0, 2047)) - 1024);
            default: return 16'(int'($urandom_range(0, 511)) - 256);
        endcase
    endfunction

    // Send a set of n samples with random content, last one marked
    task automatic send_set(int n);
        for (int i = 0; i < n; i++) begin
            send_sample($urandom_range(0, 1), pick_feature(), i == n - 1);
        end
    endtask

    task automatic test_reset_config();
        send_sample(1'b1, 16'sh7FFF, 1'b0);
        send_sample(1'b0, -16'sh8000, 1'b0);
        send_sample(1'b1, 16'sh0000, 1'b1);
    endtask

    task automatic test_rate_extremes();
        write_reg(REG_EPOCH_COUNT, 16'd3);
        write_reg(REG_LEARN_RATE, 16'hFFFF);
        send_sample(1'b0, 16'sh7FFF, 1'b0);
        send_sample(1'b1, -16'sh8000, 1'b0);
        send_sample(1'b0, 16'sh0100, 1'b0);
        send_sample(1'b1, -16'sh0100, 1'b1);
        write_reg(REG_LEARN_RATE, 16'd1);
        send_set(4);
        // weights must stay at 1.0
        write_reg(REG_LEARN_RATE, 16'd0);
        send_set(4);
    endtask

    task automatic test_zero_epochs();
        write_reg(REG_LEARN_RATE, 16'd5000);
        write_reg(REG_EPOCH_COUNT, 16'd0);
        send_set(3);
        write_reg(REG_EPOCH_COUNT, 16'd1);
        send_sample(1'b1, 16'sh0040, 1'b1);
    endtask

    task automatic test_max_epochs();
        write_reg(REG_LEARN_RATE, 16'd300);
        write_reg(REG_EPOCH_COUNT, 16'hFFFF);
        send_sample(1'b1, 16'sh0080, 1'b1);
    endtask

    // Overfill the store; the last mark sits on a dropped beat
    task automatic test_store_full();
        write_reg(REG_EPOCH_COUNT, 16'd1);
        write_reg(REG_LEARN_RATE, 16'd2000);
        send_set(MAX_SAMPLES + 6);
    endtask

    task automatic test_random(int n_items);
        int sent;
        sent = 0;
        while (sent < n_items) begin
            int n;
            if ($urandom_range(0, 7) == 0) begin
                write_reg(REG_LEARN_RATE, 16'($urandom));
                write_reg(REG_EPOCH_COUNT, 16'($urandom_range(1, 6)));
            end
            if (sent > n_items * 4 / 5) idle_on = 1'b0;
            n = $urandom_range(1, 16);
            send_set(n);
            sent += n;
            // stop sending until all weights are back
            if ($urandom_range(0, 15) == 0) drain();
        end
    endtask

    // Compare each result beat with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (weights_q.size() == 0) begin
                $display("%t: unexpected result bias=%h slope=%h",
                         $realtime, o_bias_weight, o_slope_weight);
                n_errors++;
            end else begin
                t_weights w;
                w = weights_q.pop_front();
                if (o_bias_weight !== w.bias) begin
                    $display("%t: bias expected %h actual %h",
                             $realtime, w.bias, o_bias_weight);
                    n_errors++;
                end
                if (o_slope_weight !== w.slope) begin
                    $display("%t: slope expected %h actual %h",
                             $realtime, w.slope, o_slope_weight);
                    n_errors++;
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        n_errors = 0;
        n_cycles = 0;
        n_stored = 0;
        rate_q   = 16'd66;
        epochs_q = 16'd999;
        idle_on  = 1'b1;
        fill_sigmoid_lut();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_config();
        test_rate_extremes();
        test_zero_epochs();
        test_max_epochs();
        test_store_full();
        test_random(300);
        drain();
        repeat (20) @(posedge i_clk);
        if (n_errors == 0 && weights_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/lrt_pkg.sv
sv/lrt_store.sv
sv/logistic_regression_trainer_unit.sv
tb/tb_top.sv
